[design/tlcw_pkg.sv]
// ----------------------------------------------------------------------------
// tlcw_pkg
// Shared types, codes and helper functions for the typed limit clamp writer.
// ----------------------------------------------------------------------------
package tlcw_pkg;

   // Type modes of a request
   localparam logic [2:0] MODE_U8   = 3'd0;
   localparam logic [2:0] MODE_S8   = 3'd1;
   localparam logic [2:0] MODE_U16  = 3'd2;
   localparam logic [2:0] MODE_S16  = 3'd3;
   localparam logic [2:0] MODE_U32  = 3'd4;
   localparam logic [2:0] MODE_S32  = 3'd5;
   localparam logic [2:0] MODE_FP32 = 3'd6;
   localparam logic [2:0] MODE_CMD  = 3'd7;

   // Result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ORDER     = 2'd1;
   localparam logic [1:0] STATUS_NONFINITE = 2'd2;
   localparam logic [1:0] STATUS_TYPE      = 2'd3;

   localparam logic [31:0] EXP_ALL_ONES = 32'h7F80_0000;
   localparam logic [31:0] SIGN32       = 32'h8000_0000;
   localparam logic [31:0] MASK8        = 32'h0000_00FF;
   localparam logic [31:0] MASK16       = 32'h0000_FFFF;
   localparam logic [31:0] SIGN8        = 32'h0000_0080;
   localparam logic [31:0] SIGN16       = 32'h0000_8000;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] request_value;
      logic [31:0] upper_limit;
      logic [31:0] lower_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] clamped_value;
      logic [31:0] stored_upper;
      logic [31:0] stored_lower;
   } rsp_type;

   // Decoded request: masked patterns and their order keys
   typedef struct packed {
      logic        is_cmd;
      logic        non_finite;
      logic [31:0] val;
      logic [31:0] upper;
      logic [31:0] lower;
      logic [31:0] key_val;
      logic [31:0] key_upper;
      logic [31:0] key_lower;
   } dec_type;

   // After the first compare: status known, value clamped against upper
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] val;
      logic [31:0] upper;
      logic [31:0] lower;
      logic [31:0] key_val;
      logic [31:0] key_lower;
   } cmp_type;

   function automatic logic [31:0] width_mask(input logic [2:0] mode);
      logic [31:0] mask;
      unique case (mode)
         MODE_U8, MODE_S8:   mask = MASK8;
         MODE_U16, MODE_S16: mask = MASK16;
         default:            mask = '1;
      endcase
      return mask;
   endfunction

   // Map a masked pattern onto an unsigned key that sorts in the type's order
   function automatic logic [31:0] order_key(input logic [2:0] mode,
                                             input logic [31:0] bits);
      logic [31:0] key;
      logic [31:0] b;
      b = bits;
      unique case (mode)
         MODE_U8, MODE_U16, MODE_U32: key = bits;
         MODE_S8:  key = bits ^ SIGN8;
         MODE_S16: key = bits ^ SIGN16;
         MODE_S32: key = bits ^ SIGN32;
         default: begin
            // fold negative zero onto positive zero
            if (b == SIGN32) begin
               b = '0;
            end
            key = b[31] ? ~b : (b | SIGN32);
         end
      endcase
      return key;
   endfunction

endpackage

[design/tlcw_decode.sv]
// ----------------------------------------------------------------------------
// tlcw_decode
// Cut the request patterns to the type width and form their order keys.
// ----------------------------------------------------------------------------
module tlcw_decode (
   input  tlcw_pkg::req_type req,
   output tlcw_pkg::dec_type dec
);
   import tlcw_pkg::*;

   logic [31:0] mask;
   logic [31:0] val;
   logic [31:0] upper;
   logic [31:0] lower;

   assign mask  = width_mask(req.mode);
   assign val   = req.request_value & mask;
   assign upper = req.upper_limit & mask;
   assign lower = req.lower_limit & mask;

   always_comb begin
      dec.is_cmd     = (req.mode == MODE_CMD);
      dec.non_finite = (req.mode == MODE_FP32) &&
                       (((val & EXP_ALL_ONES) == EXP_ALL_ONES) ||
                        ((upper & EXP_ALL_ONES) == EXP_ALL_ONES) ||
                        ((lower & EXP_ALL_ONES) == EXP_ALL_ONES));
      dec.val        = val;
      dec.upper      = upper;
      dec.lower      = lower;
      dec.key_val    = order_key(req.mode, val);
      dec.key_upper  = order_key(req.mode, upper);
      dec.key_lower  = order_key(req.mode, lower);
   end

endmodule

[design/typed_limit_clamp_writer.sv]
// ----------------------------------------------------------------------------
// typed_limit_clamp_writer
// Check a typed value and its limits, clamp the value and return all three.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid, req_stall, req_data) carries a type mode
//   and three 32-bit patterns: value, upper limit and lower limit. The result
//   channel (rsp_valid, rsp_stall, rsp_data) returns one transfer per request:
//   a status plus the clamped value and both limits, zero-extended from the
//   type width, or all zero when the request is rejected.
//   rsp_valid rises once the request has passed the three register stages;
//   throughput is one request per cycle while req_stall stays low. The
//   three register stages hold decode and key forming, limit order check
//   with the upper clamp, then the lower clamp in the output register.
//   Each stage loads whenever it is empty or the stage after it moves, so
//   bubbles collapse and a request is taken while a finished result still
//   waits on rsp_stall. With all stages full and rsp_stall high, req_stall
//   rises and every stage holds.
//   Reset clears the stage valid bits; the block holds no other state.
// ----------------------------------------------------------------------------
module typed_limit_clamp_writer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tlcw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tlcw_pkg::rsp_type rsp_data
);
   import tlcw_pkg::*;

   // Stage valid bits and payloads
   logic    s1_valid_ff;
   logic    s2_valid_ff;
   logic    s3_valid_ff;
   dec_type s1_data_ff;
   dec_type s1_data_in;
   cmp_type s2_data_ff;
   cmp_type s2_data_in;
   rsp_type s3_data_ff;
   rsp_type s3_data_in;

   // Advance enables, from the output back to the input
   logic adv3;
   logic adv2;
   logic adv1;

   assign adv3 = !s3_valid_ff || !rsp_stall;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   assign req_stall = !adv1;
   assign rsp_valid = s3_valid_ff;
   assign rsp_data  = s3_data_ff;

   // Stage 1: mask to type width, form order keys, flag bad operands
   tlcw_decode u_decode (
      .req (req_data),
      .dec (s1_data_in)
   );

   // Stage 2: decide status, clamp against the upper limit
   always_comb begin
      s2_data_in.upper     = s1_data_ff.upper;
      s2_data_in.lower     = s1_data_ff.lower;
      s2_data_in.key_lower = s1_data_ff.key_lower;
      if (s1_data_ff.is_cmd) begin
         s2_data_in.status = STATUS_TYPE;
      end else if (s1_data_ff.non_finite) begin
         s2_data_in.status = STATUS_NONFINITE;
      end else if (s1_data_ff.key_lower > s1_data_ff.key_upper) begin
         s2_data_in.status = STATUS_ORDER;
      end else begin
         s2_data_in.status = STATUS_OK;
      end
      if (s1_data_ff.key_val > s1_data_ff.key_upper) begin
         s2_data_in.val     = s1_data_ff.upper;
         s2_data_in.key_val = s1_data_ff.key_upper;
      end else begin
         s2_data_in.val     = s1_data_ff.val;
         s2_data_in.key_val = s1_data_ff.key_val;
      end
   end

   // Stage 3: clamp against the lower limit, zero everything on rejection
   always_comb begin
      s3_data_in.status = s2_data_ff.status;
      if (s2_data_ff.status != STATUS_OK) begin
         s3_data_in.clamped_value = '0;
         s3_data_in.stored_upper  = '0;
         s3_data_in.stored_lower  = '0;
      end else begin
         s3_data_in.clamped_value = (s2_data_ff.key_val < s2_data_ff.key_lower) ?
                                    s2_data_ff.lower : s2_data_ff.val;
         s3_data_in.stored_upper  = s2_data_ff.upper;
         s3_data_in.stored_lower  = s2_data_ff.lower;
      end
   end

   // Valid bits: load when the stage advances, otherwise hold
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Payload registers: no reset, hold while stalled
   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_data_ff <= s1_data_in;
      end
      if (adv2) begin
         s2_data_ff <= s2_data_in;
      end
      if (adv3) begin
         s3_data_ff <= s3_data_in;
      end
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the typed limit clamp writer. A short table of
// hand-picked requests covers every type mode, the field extremes, rejected
// types, non-finite fp32 operands, inverted limits and signed zeros. Random
// traffic follows, with sender gaps, receiver stalls and one long result
// hold-off. Every result transfer is compared field by field with an
// independent model of the clamp, kept in order in a queue.
// ----------------------------------------------------------------------------
module tb_top;
   import tlcw_pkg::*;

   localparam int HOLDOFF_CYCLES = 60;
   localparam int PHASE_ITEMS    = 340;
   localparam int PRESSURE_ITEMS = 120;
   localparam int DRAIN_CYCLES   = 8;

   // One row of the directed table. When has_fixed is set, the expected
   // result is given in the row; otherwise the model works it out.
   typedef struct {
      req_type stim;
      bit      has_fixed;
      rsp_type fixed;
   } directed_row_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type          expected_writes[$];
   directed_row_type directed_rows[$];
   int               mismatch_count = 0;

   // Percentages of cycles in which the sender idles and the receiver stalls
   int idle_pct  = 0;
   int stall_pct = 0;

   // Long hold-off handshake between the main sequence and the receiver
   bit holdoff_armed = 1'b0;
   bit holdoff_done  = 1'b0;

   typed_limit_clamp_writer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the handshake locks up
   initial begin
      #2ms;
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Model of the block
   // ------------------------------------------------------------------------

   // Low bits that a type actually uses
   function automatic logic [31:0] field_mask(input logic [2:0] mode);
      case (mode)
         MODE_U8, MODE_S8:   return MASK8;
         MODE_U16, MODE_S16: return MASK16;
         default:            return 32'hFFFF_FFFF;
      endcase
   endfunction

   // Rank of a masked pattern: larger rank means larger value of the type.
   // Signed integers flip the sign bit; fp32 folds -0 onto +0 and mirrors
   // negatives so that unsigned compare follows IEEE order.
   function automatic logic [31:0] type_rank(input logic [2:0] mode,
                                             input logic [31:0] bits);
      case (mode)
         MODE_S8:  return {bits[31:8], ~bits[7], bits[6:0]};
         MODE_S16: return {bits[31:16], ~bits[15], bits[14:0]};
         MODE_S32: return {~bits[31], bits[30:0]};
         MODE_FP32: begin
            if (bits[30:0] == 31'd0) begin
               return SIGN32;
            end
            return bits[31] ? ~bits : {1'b1, bits[30:0]};
         end
         default:  return bits;
      endcase
   endfunction

   function automatic bit exp_saturated(input logic [31:0] bits);
      return (bits & EXP_ALL_ONES) == EXP_ALL_ONES;
   endfunction

   // Expected result of one write request
   function automatic rsp_type clamp_predict(input req_type r);
      rsp_type     w;
      logic [31:0] m;
      logic [31:0] v;
      logic [31:0] hi;
      logic [31:0] lo;
      m  = field_mask(r.mode);
      v  = r.request_value & m;
      hi = r.upper_limit & m;
      lo = r.lower_limit & m;
      w  = '0;
      if (r.mode == MODE_CMD) begin
         w.status = STATUS_TYPE;
      end else if (r.mode == MODE_FP32 &&
                   (exp_saturated(v) || exp_saturated(hi) || exp_saturated(lo))) begin
         w.status = STATUS_NONFINITE;
      end else if (type_rank(r.mode, lo) > type_rank(r.mode, hi)) begin
         w.status = STATUS_ORDER;
      end else begin
         // clamp against the upper limit first, then the lower
         if (type_rank(r.mode, v) > type_rank(r.mode, hi)) begin
            v = hi;
         end
         if (type_rank(r.mode, v) < type_rank(r.mode, lo)) begin
            v = lo;
         end
         w.status        = STATUS_OK;
         w.clamped_value = v;
         w.stored_upper  = hi;
         w.stored_lower  = lo;
      end
      return w;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------

   // Pattern biased toward the type's edges, with random unused high bits
   function automatic logic [31:0] pick_pattern(input logic [2:0] mode);
      logic [31:0] m;
      logic [31:0] msb;
      logic [31:0] low;
      m   = field_mask(mode);
      msb = m ^ (m >> 1);
      case ($urandom_range(0, 9))
         5:       low = '0;
         6:       low = '1;
         7:       low = msb;
         8:       low = m ^ msb;
         9:       low = $urandom_range(0, 1) ? 32'($urandom_range(0, 3))
                                             : ~32'($urandom_range(0, 3));
         default: low = $urandom;
      endcase
      return ($urandom & ~m) | (low & m);
   endfunction

   function automatic req_type random_request();
      req_type     r;
      logic [31:0] swap;
      logic [31:0] m;
      r.mode = ($urandom_range(0, 99) < 6) ? MODE_CMD : 3'($urandom_range(0, 6));
      r.request_value = pick_pattern(r.mode);
      r.upper_limit   = pick_pattern(r.mode);
      r.lower_limit   = pick_pattern(r.mode);
      m = field_mask(r.mode);
      if (r.mode == MODE_FP32) begin
         // keep fp32 operands finite most of the time
         if (exp_saturated(r.request_value)) r.request_value ^= 32'h0080_0000;
         if (exp_saturated(r.upper_limit))   r.upper_limit   ^= 32'h0080_0000;
         if (exp_saturated(r.lower_limit))   r.lower_limit   ^= 32'h0080_0000;
         if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 2))
               0:       r.request_value |= EXP_ALL_ONES;
               1:       r.upper_limit   |= EXP_ALL_ONES;
               default: r.lower_limit   |= EXP_ALL_ONES;
            endcase
         end
      end
      // order the limits in most requests so that the clamp path is reached
      if ($urandom_range(0, 99) < 85 &&
          type_rank(r.mode, r.lower_limit & m) > type_rank(r.mode, r.upper_limit & m)) begin
         swap          = r.upper_limit;
         r.upper_limit = r.lower_limit;
         r.lower_limit = swap;
      end
      case ($urandom_range(0, 19))
         0:       r.request_value = r.upper_limit;
         1:       r.request_value = r.lower_limit;
         default: ;
      endcase
      return r;
   endfunction

   function automatic void add_row(input logic [2:0] mode, input logic [31:0] v,
                                   input logic [31:0] hi, input logic [31:0] lo,
                                   input bit has_fixed, input logic [1:0] status,
                                   input logic [31:0] c, input logic [31:0] su,
                                   input logic [31:0] sl);
      directed_row_type row;
      row.stim      = '{mode: mode, request_value: v, upper_limit: hi, lower_limit: lo};
      row.has_fixed = has_fixed;
      row.fixed     = '{status: status, clamped_value: c, stored_upper: su, stored_lower: sl};
      directed_rows.push_back(row);
   endfunction

   // Offer one request, hold it until the transfer, then queue its result.
   // Valid is not lowered at the end so that back-to-back transfers stay high.
   task automatic send_request(input req_type item, input rsp_type want);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do begin
         @(posedge clock);
      end while (req_stall !== 1'b0);
      expected_writes.push_back(want);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (holdoff_armed && !holdoff_done) begin
            // hold the result channel so the pipe fills and stalls its input
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
            holdoff_done = 1'b1;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_writes.size() == 0) begin
            report_mismatch($sformatf("result transfer with nothing pending: %h", rsp_data));
         end else begin
            want = expected_writes.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_data.status, want.status));
            if (rsp_data.clamped_value !== want.clamped_value)
               report_mismatch($sformatf("clamped_value %h, want %h",
                                         rsp_data.clamped_value, want.clamped_value));
            if (rsp_data.stored_upper !== want.stored_upper)
               report_mismatch($sformatf("stored_upper %h, want %h",
                                         rsp_data.stored_upper, want.stored_upper));
            if (rsp_data.stored_lower !== want.stored_lower)
               report_mismatch($sformatf("stored_lower %h, want %h",
                                         rsp_data.stored_lower, want.stored_lower));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      req_type item;
      int      phase_idle[4];
      int      phase_stall[4];

      phase_idle  = '{0, 54, 0, 25};
      phase_stall = '{0, 0, 54, 25};

      // extremes with the answer read straight off the definition
      add_row(MODE_U8,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              1, STATUS_OK, 32'h0, 32'h0, 32'h0);
      add_row(MODE_U8,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
              1, STATUS_OK, 32'hFF, 32'hFF, 32'h0);
      add_row(MODE_S8,  32'h0000_0080, 32'h0000_007F, 32'h0000_0080,
              1, STATUS_OK, 32'h80, 32'h7F, 32'h80);
      add_row(MODE_S8,  32'h0000_0000, 32'h0000_0080, 32'h0000_007F,
              1, STATUS_ORDER, 32'h0, 32'h0, 32'h0);
      // unused high bits must be dropped
      add_row(MODE_U8,  32'hFFFF_FF05, 32'h0000_0010, 32'hAAAA_AA03,
              1, STATUS_OK, 32'h05, 32'h10, 32'h03);
      add_row(MODE_U16, 32'h1234_FFFF, 32'hABCD_1000, 32'h0000_0010,
              0, STATUS_OK, 32'h0, 32'h0, 32'h0);
      add_row(MODE_S16, 32'h0000_8000, 32'h0000_7FFF, 32'h0000_FFFF,
              0, STATUS_OK, 32'h0, 32'h0, 32'h0);
      add_row(MODE_S16, 32'h0000_7FFF, 32'hFFFF_8000, 32'h0000_8000,
              0, STATUS_OK, 32'h0, 32'h0, 32'h0);
      add_row(MODE_U32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
              1, STATUS_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
      add_row(MODE_U32, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001,
              1, STATUS_ORDER, 32'h0, 32'h0, 32'h0);
      add_row(MODE_S32, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              1, STATUS_OK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      add_row(MODE_S32, 32'h0000_0005, 32'hFFFF_FFFF, 32'h8000_0000,
              0, STATUS_OK, 32'h0, 32'h0, 32'h0);
      // non-finite fp32 operands, one of them with inverted limits as well
      add_row(MODE_FP32, 32'h7F80_0000, 32'h3F80_0000, 32'h0000_0000,
              1, STATUS_NONFINITE, 32'h0, 32'h0, 32'h0);
      add_row(MODE_FP32, 32'h0000_0000, 32'h7FC0_0000, 32'h0000_0000,
              1, STATUS_NONFINITE, 32'h0, 32'h0, 32'h0);
      add_row(MODE_FP32, 32'h0000_0000, 32'hFF80_0000, 32'hBF80_0000,
              1, STATUS_NONFINITE, 32'h0, 32'h0, 32'h0);
      // signed zeros compare equal and pass through unchanged
      add_row(MODE_FP32, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000,
              1, STATUS_OK, 32'h8000_0000, 32'h0, 32'h0);
      add_row(MODE_FP32, 32'h3F80_0000, 32'h8000_0000, 32'h0000_0000,
              1, STATUS_OK, 32'h8000_0000, 32'h8000_0000, 32'h0);
      add_row(MODE_FP32, 32'hC000_0000, 32'h3F80_0000, 32'hBF80_0000,
              0, STATUS_OK, 32'h0, 32'h0, 32'h0);
      add_row(MODE_FP32, 32'h0000_0000, 32'hBF80_0000, 32'h3F80_0000,
              1, STATUS_ORDER, 32'h0, 32'h0, 32'h0);
      add_row(MODE_FP32, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
              1, STATUS_OK, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF);
      add_row(MODE_FP32, 32'h0000_0001, 32'h0000_0000, 32'h8000_0001,
              0, STATUS_OK, 32'h0, 32'h0, 32'h0);
      // command type is always refused
      add_row(MODE_CMD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
              1, STATUS_TYPE, 32'h0, 32'h0, 32'h0);
      add_row(MODE_CMD, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              1, STATUS_TYPE, 32'h0, 32'h0, 32'h0);

      // hold reset, then release it for good
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table back to back
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].stim,
                      directed_rows[i].has_fixed ? directed_rows[i].fixed
                                                 : clamp_predict(directed_rows[i].stim));
      end

      // random traffic under each idling mix
      for (int p = 0; p < 4; p++) begin
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         repeat (PHASE_ITEMS) begin
            item = random_request();
            send_request(item, clamp_predict(item));
         end
      end

      // keep offering while the receiver holds off, so the pipe backs up
      idle_pct      = 0;
      stall_pct     = 0;
      holdoff_armed = 1'b1;
      repeat (PRESSURE_ITEMS) begin
         item = random_request();
         send_request(item, clamp_predict(item));
      end
      req_valid <= 1'b0;

      // drain, then give stray results a chance to show up
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_writes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[sim.f]
design/tlcw_pkg.sv
design/tlcw_decode.sv
design/typed_limit_clamp_writer.sv
tb/sv/tb_top.sv
